@@ design/sspb_pkg.sv @@
// Shared types and constants for the scaled sprite pixel blit.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sspb_pkg;

    localparam int TEX_MAX_DEF    = 64;
    localparam int TEXEL_BITS_DEF = 32;

    localparam int POS_W      = 12;
    localparam int COLOR_W    = 32;
    localparam int COORD_W    = 14;
    localparam int SIZE_W     = 7;
    localparam int QUOT_W     = SIZE_W;
    localparam int NUM_W      = COORD_W + SIZE_W;
    localparam int IDX_W      = 9;
    localparam int LIN_W      = 2 * IDX_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COORD_W;

    localparam logic [COLOR_W-1:0] KEY_MASK   = 32'h00FF_FFFF;
    localparam logic [SIZE_W-1:0]  SIZE_RESET = 7'd64;

    // Pipeline stage numbers: front, multiply, one stage per quotient bit,
    // texture store access, output register.
    localparam int STG_MUL      = 1;
    localparam int STG_DIV_LAST = QUOT_W + 1;
    localparam int STG_RAM      = QUOT_W + 2;
    localparam int STG_OUT      = QUOT_W + 3;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_DRAW = 1'b1
    } sspb_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPRITE_LEFT   = 3'd0,
        REG_SPRITE_RIGHT  = 3'd1,
        REG_SPRITE_TOP    = 3'd2,
        REG_SPRITE_BOTTOM = 3'd3,
        REG_TEX_WIDTH     = 3'd4,
        REG_TEX_HEIGHT    = 3'd5
    } sspb_reg_t;

    typedef struct packed {
        sspb_kind_t         kind;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [COLOR_W-1:0] texel;
    } sspb_in_t;

    typedef struct packed {
        logic [POS_W-1:0]   out_x;
        logic [POS_W-1:0]   out_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               write_enable;
    } sspb_out_t;

    // Request fields that ride alongside the scaling pipeline.
    typedef struct packed {
        sspb_kind_t         kind;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [COLOR_W-1:0] texel;
        logic               hit;
    } sspb_tag_t;

    typedef struct packed {
        sspb_tag_t          tag;
        logic [COORD_W-1:0] off_x;
        logic [COORD_W-1:0] span_x;
        logic [COORD_W-1:0] off_y;
        logic [COORD_W-1:0] span_y;
    } sspb_front_t;

endpackage

`default_nettype wire

@@ design/sspb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Uses sspb_pkg for its default sizes only.
`default_nettype none

module sspb_ram
    import sspb_pkg::*;
#(
    parameter int WIDTH  = TEXEL_BITS_DEF,
    parameter int DEPTH  = TEX_MAX_DEF * TEX_MAX_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/sspb_front.sv @@
// Front stage: rectangle hit test and offsets of the pixel within the sprite.
// Depends on sspb_pkg.
`default_nettype none

module sspb_front
    import sspb_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire sspb_in_t                  s_data,
    input  wire logic signed [COORD_W-1:0] sprite_left,
    input  wire logic signed [COORD_W-1:0] sprite_right,
    input  wire logic signed [COORD_W-1:0] sprite_top,
    input  wire logic signed [COORD_W-1:0] sprite_bottom,
    output sspb_front_t                    front_out
);

    sspb_front_t front_reg;
    sspb_front_t front_next;

    logic signed [COORD_W:0] x_s, y_s;
    logic signed [COORD_W:0] left_s, right_s, top_s, bottom_s;
    logic signed [COORD_W:0] dx, dy, wx, wy;

    always_comb begin
        x_s      = signed'({3'b000, s_data.pos_x});
        y_s      = signed'({3'b000, s_data.pos_y});
        left_s   = {sprite_left[COORD_W-1], sprite_left};
        right_s  = {sprite_right[COORD_W-1], sprite_right};
        top_s    = {sprite_top[COORD_W-1], sprite_top};
        bottom_s = {sprite_bottom[COORD_W-1], sprite_bottom};
        dx = x_s - left_s;
        dy = y_s - top_s;
        wx = right_s - left_s;
        wy = bottom_s - top_s;

        front_next.tag.kind  = s_data.kind;
        front_next.tag.pos_x = s_data.pos_x;
        front_next.tag.pos_y = s_data.pos_y;
        front_next.tag.texel = s_data.texel;
        front_next.tag.hit   = (x_s >= left_s) && (x_s < right_s) &&
                               (y_s >= top_s) && (y_s < bottom_s);
        // inside a non-empty rectangle the offset is non-negative and the span positive
        front_next.off_x  = dx[COORD_W-1:0];
        front_next.off_y  = dy[COORD_W-1:0];
        front_next.span_x = wx[COORD_W-1:0];
        front_next.span_y = wy[COORD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            front_reg <= front_next;
        end
    end

    assign front_out = front_reg;

endmodule

`default_nettype wire

@@ design/sspb_scaler.sv @@
// Scales one axis: offset * size in one stage, then a restoring divide
// by the span, one quotient bit per stage. Depends on sspb_pkg.
`default_nettype none

module sspb_scaler
    import sspb_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic [QUOT_W:0]     en,
    input  wire logic [COORD_W-1:0]  off,
    input  wire logic [COORD_W-1:0]  span,
    input  wire logic [SIZE_W-1:0]   size,
    output logic      [QUOT_W-1:0]   quot
);

    logic [NUM_W-1:0]   rem_reg  [QUOT_W];
    logic [COORD_W-1:0] span_reg [QUOT_W];
    logic [QUOT_W-1:0]  quot_reg [QUOT_W+1];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rem_reg[0]  <= NUM_W'(off) * NUM_W'(size);
            span_reg[0] <= span;
            quot_reg[0] <= '0;
        end
    end

    // offset < span, so the quotient is below size and fits QUOT_W bits
    for (genvar j = 1; j <= QUOT_W; j++) begin : g_step
        localparam int B = QUOT_W - j;

        logic [NUM_W-1:0]  divisor;
        logic              take;
        logic [NUM_W-1:0]  rem_next;
        logic [QUOT_W-1:0] quot_next;

        always_comb begin
            divisor   = NUM_W'(span_reg[j-1]) << B;
            take      = rem_reg[j-1] >= divisor;
            rem_next  = take ? (rem_reg[j-1] - divisor) : rem_reg[j-1];
            quot_next = {quot_reg[j-1][QUOT_W-2:0], take};
        end

        always_ff @(posedge aclk) begin
            if (en[j]) begin
                quot_reg[j] <= quot_next;
            end
        end

        if (j < QUOT_W) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en[j]) begin
                    rem_reg[j]  <= rem_next;
                    span_reg[j] <= span_reg[j-1];
                end
            end
        end
    end

    assign quot = quot_reg[QUOT_W];

endmodule

`default_nettype wire

@@ design/scaled_sprite_pixel_blit.sv @@
// Scaled sprite pixel blit with color key.
// Input channel s_valid/s_ready/s_data carries requests: a load request
// (kind 0) writes its texel at (pos_x, pos_y) of the texture store when both
// are below TEX_MAX; a draw request (kind 1) names a screen pixel.
// Each draw request gives one result on m_valid/m_ready/m_data; loads give
// none. A pixel inside the sprite rectangle is mapped to texel coordinates
// offset * tex size / rectangle span and the texel is fetched; write_enable
// is set when it is in bounds and its low 24 color bits are not zero.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
// A request passes eleven register stages, the first loaded at acceptance:
// one front stage, one multiply stage, seven divide stages (one quotient
// bit each), the texture store read and the output register.
// Throughput: one request per cycle while the receiver takes results. Every
// stage carries its own valid bit and holds only when the stage after it is
// full and held, so bubbles fill while the receiver stalls; s_ready falls
// only when all stages are full.
// Reset (aresetn low, synchronous) empties the pipeline and restores the
// registers: rectangle 0, texture size 64 by 64. Texture contents are
// undefined until loaded. Depends on sspb_pkg and all sspb_ modules.
`default_nettype none

module scaled_sprite_pixel_blit
    import sspb_pkg::*;
#(
    parameter int TEX_MAX    = TEX_MAX_DEF,
    parameter int TEXEL_BITS = TEXEL_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire sspb_in_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output sspb_out_t                  m_data
);

    localparam int DEPTH  = TEX_MAX * TEX_MAX;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic signed [COORD_W-1:0] sprite_left_reg, sprite_right_reg;
    logic signed [COORD_W-1:0] sprite_top_reg, sprite_bottom_reg;
    logic [SIZE_W-1:0]         tex_width_reg, tex_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sprite_left_reg   <= '0;
            sprite_right_reg  <= '0;
            sprite_top_reg    <= '0;
            sprite_bottom_reg <= '0;
            tex_width_reg     <= SIZE_RESET;
            tex_height_reg    <= SIZE_RESET;
        end else if (cfg_we) begin
            unique case (sspb_reg_t'(cfg_index))
                REG_SPRITE_LEFT:   sprite_left_reg   <= signed'(cfg_wdata);
                REG_SPRITE_RIGHT:  sprite_right_reg  <= signed'(cfg_wdata);
                REG_SPRITE_TOP:    sprite_top_reg    <= signed'(cfg_wdata);
                REG_SPRITE_BOTTOM: sprite_bottom_reg <= signed'(cfg_wdata);
                REG_TEX_WIDTH:     tex_width_reg     <= cfg_wdata[SIZE_W-1:0];
                REG_TEX_HEIGHT:    tex_height_reg    <= cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage valid bits and per-stage advance
    // ---------------------------------------------------------------
    logic [STG_OUT:0] v_reg;
    logic [STG_OUT:0] v_next;
    logic [STG_OUT:0] en;

    assign en[STG_OUT] = !v_reg[STG_OUT] || m_ready;
    for (genvar k = 0; k < STG_OUT; k++) begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    sspb_tag_t tag_last;

    always_comb begin
        v_next[0] = s_valid;
        for (int k = 1; k <= STG_DIV_LAST; k++) begin
            v_next[k] = v_reg[k-1];
        end
        // drop loads at the texture store access; they give no result
        v_next[STG_RAM] = v_reg[STG_DIV_LAST] && (tag_last.kind == KIND_DRAW);
        v_next[STG_OUT] = v_reg[STG_RAM];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= (v_reg & ~en) | (v_next & en);
        end
    end

    assign s_ready = en[0];

    // ---------------------------------------------------------------
    // Front, scaling and tag pipeline
    // ---------------------------------------------------------------
    sspb_front_t       front_q;
    logic [QUOT_W-1:0] tx, ty;

    sspb_front u_front (
        .aclk          (aclk),
        .en            (en[0]),
        .s_data        (s_data),
        .sprite_left   (sprite_left_reg),
        .sprite_right  (sprite_right_reg),
        .sprite_top    (sprite_top_reg),
        .sprite_bottom (sprite_bottom_reg),
        .front_out     (front_q)
    );

    sspb_scaler u_scale_x (
        .aclk (aclk),
        .en   (en[STG_DIV_LAST:STG_MUL]),
        .off  (front_q.off_x),
        .span (front_q.span_x),
        .size (tex_width_reg),
        .quot (tx)
    );

    sspb_scaler u_scale_y (
        .aclk (aclk),
        .en   (en[STG_DIV_LAST:STG_MUL]),
        .off  (front_q.off_y),
        .span (front_q.span_y),
        .size (tex_height_reg),
        .quot (ty)
    );

    sspb_tag_t tag_reg [STG_MUL:STG_DIV_LAST];

    for (genvar k = STG_MUL; k <= STG_DIV_LAST; k++) begin : g_tag
        if (k == STG_MUL) begin : g_first
            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    tag_reg[k] <= front_q.tag;
                end
            end
        end else begin : g_next
            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    tag_reg[k] <= tag_reg[k-1];
                end
            end
        end
    end

    assign tag_last = tag_reg[STG_DIV_LAST];

    // ---------------------------------------------------------------
    // Texture store access
    // ---------------------------------------------------------------
    logic              load_ok, draw_ok;
    logic [IDX_W-1:0]  ax, ay;
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we, ram_re;
    logic [TEXEL_BITS-1:0] ram_rdata;

    always_comb begin
        load_ok = ((POS_W+1)'(tag_last.pos_x) < (POS_W+1)'(TEX_MAX)) &&
                  ((POS_W+1)'(tag_last.pos_y) < (POS_W+1)'(TEX_MAX));
        draw_ok = tag_last.hit &&
                  (tx < tex_width_reg) && (ty < tex_height_reg) &&
                  (IDX_W'(tx) < IDX_W'(TEX_MAX)) && (IDX_W'(ty) < IDX_W'(TEX_MAX));
        if (tag_last.kind == KIND_DRAW) begin
            ax = IDX_W'(tx);
            ay = IDX_W'(ty);
        end else begin
            ax = tag_last.pos_x[IDX_W-1:0];
            ay = tag_last.pos_y[IDX_W-1:0];
        end
        ram_addr = ADDR_W'(LIN_W'(ay) * LIN_W'(TEX_MAX) + LIN_W'(ax));
        ram_we = en[STG_RAM] && v_reg[STG_DIV_LAST] &&
                 (tag_last.kind == KIND_LOAD) && load_ok;
        ram_re = en[STG_RAM] && v_reg[STG_DIV_LAST] &&
                 (tag_last.kind == KIND_DRAW) && draw_ok;
    end

    sspb_ram #(
        .WIDTH (TEXEL_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (tag_last.texel[TEXEL_BITS-1:0]),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    logic [POS_W-1:0] ram_x_reg, ram_y_reg;
    logic             ram_ok_reg;

    always_ff @(posedge aclk) begin
        if (en[STG_RAM]) begin
            ram_x_reg  <= tag_last.pos_x;
            ram_y_reg  <= tag_last.pos_y;
            ram_ok_reg <= draw_ok;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    sspb_out_t out_reg;
    sspb_out_t out_next;

    always_comb begin
        out_next.out_x        = ram_x_reg;
        out_next.out_y        = ram_y_reg;
        out_next.pixel_color  = ram_ok_reg ? COLOR_W'(ram_rdata) : '0;
        out_next.write_enable = ram_ok_reg && ((out_next.pixel_color & KEY_MASK) != '0);
    end

    always_ff @(posedge aclk) begin
        if (en[STG_OUT]) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = v_reg[STG_OUT];
    assign m_data  = out_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&v_reg))
        else $error("input held off while a pipeline stage is empty");

    a_store_one_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("texture store written and read in the same cycle");

    a_key_respected: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.write_enable) |-> ((m_data.pixel_color & KEY_MASK) != '0))
        else $error("keyed texel marked for writing");

endmodule

`default_nettype wire

@@ test/scaled_sprite_pixel_blit_test.sv @@
// Self-checking testbench for scaled_sprite_pixel_blit: texel loads, scaled draws, color key.
// Needs sspb_pkg and the block's RTL; drives requests from a queue and checks every pixel.
`timescale 1ns / 1ps

module scaled_sprite_pixel_blit_test;
    import sspb_pkg::*;

    localparam int TEX_DIM      = TEX_MAX_DEF;
    localparam int SCREEN_MAX   = (1 << POS_W) - 1;
    localparam int DRAIN_CYCLES = 24;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 100;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    sspb_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    sspb_out_t             m_data;

    scaled_sprite_pixel_blit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    // Shadow of the sprite registers and the texture store
    int          spr_left   = 0;
    int          spr_right  = 0;
    int          spr_top    = 0;
    int          spr_bottom = 0;
    int          tex_w      = 64;
    int          tex_h      = 64;
    logic [31:0] texel_mem [TEX_DIM*TEX_DIM];
    bit          texel_loaded [TEX_DIM*TEX_DIM];

    sspb_in_t  request_q[$];
    sspb_out_t expected_pixels[$];
    int        send_idle_pct = 0;
    int        stall_pct     = 0;
    int        errors        = 0;

    // Map a screen pixel to a texture store index; 0 when nothing is fetched.
    function automatic bit map_to_texel(input int x, input int y, output int idx);
        int tx;
        int ty;
        idx = 0;
        if (!(x >= spr_left && x < spr_right && y >= spr_top && y < spr_bottom))
            return 1'b0;
        tx = (x - spr_left) * tex_w / (spr_right - spr_left);
        ty = (y - spr_top) * tex_h / (spr_bottom - spr_top);
        if (tx >= tex_w || ty >= tex_h || tx >= TEX_DIM || ty >= TEX_DIM)
            return 1'b0;
        idx = ty * TEX_DIM + tx;
        return 1'b1;
    endfunction

    // Apply one accepted request: store a texel or compute the drawn pixel.
    function automatic void render_request(input sspb_in_t req);
        sspb_out_t px;
        int        idx;
        if (req.kind == KIND_LOAD) begin
            if (req.pos_x < TEX_DIM && req.pos_y < TEX_DIM)
                texel_mem[int'(req.pos_y) * TEX_DIM + int'(req.pos_x)] = req.texel;
            return;
        end
        px.out_x        = req.pos_x;
        px.out_y        = req.pos_y;
        px.pixel_color  = '0;
        px.write_enable = 1'b0;
        if (map_to_texel(int'(req.pos_x), int'(req.pos_y), idx)) begin
            px.pixel_color  = texel_mem[idx];
            px.write_enable = |(texel_mem[idx] & KEY_MASK);
        end
        expected_pixels.push_back(px);
    endfunction

    // Driver: advance to the next request once the current one is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                render_request(s_data);
            if (!s_valid || s_ready) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= request_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, exp_val, act_val);
            errors++;
        end
    endfunction

    // Monitor: compare each taken pixel with the oldest prediction
    always @(posedge aclk) begin
        sspb_out_t exp_px;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected pixel at (%0d, %0d)", m_data.out_x, m_data.out_y);
                    errors++;
                end else begin
                    exp_px = expected_pixels.pop_front();
                    check_field("out_x", 32'(exp_px.out_x), 32'(m_data.out_x));
                    check_field("out_y", 32'(exp_px.out_y), 32'(m_data.out_y));
                    check_field("pixel_color", exp_px.pixel_color, m_data.pixel_color);
                    check_field("write_enable", 32'(exp_px.write_enable),
                                32'(m_data.write_enable));
                end
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [31:0] random_texel();
        logic [31:0] v;
        v = $urandom();
        if ($urandom_range(4) == 0)
            v[23:0] = '0;
        return v;
    endfunction

    task automatic queue_load(input int x, input int y, input logic [31:0] texel);
        sspb_in_t req;
        req.kind  = KIND_LOAD;
        req.pos_x = POS_W'(x);
        req.pos_y = POS_W'(y);
        req.texel = texel;
        request_q.push_back(req);
        if (x < TEX_DIM && y < TEX_DIM)
            texel_loaded[y * TEX_DIM + x] = 1'b1;
    endtask

    // Queue a draw; load its texel first if it was never written.
    task automatic queue_draw(input int x, input int y);
        sspb_in_t req;
        int       idx;
        if (map_to_texel(x, y, idx) && !texel_loaded[idx])
            queue_load(idx % TEX_DIM, idx / TEX_DIM, random_texel());
        req.kind  = KIND_DRAW;
        req.pos_x = POS_W'(x);
        req.pos_y = POS_W'(y);
        req.texel = $urandom();
        request_q.push_back(req);
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || s_valid || expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input sspb_reg_t idx, input int value);
        logic [CFG_DATA_W-1:0] raw;
        raw = CFG_DATA_W'(value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= raw;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_SPRITE_LEFT:   spr_left   = int'($signed(raw));
            REG_SPRITE_RIGHT:  spr_right  = int'($signed(raw));
            REG_SPRITE_TOP:    spr_top    = int'($signed(raw));
            REG_SPRITE_BOTTOM: spr_bottom = int'($signed(raw));
            REG_TEX_WIDTH:     tex_w      = int'(raw[SIZE_W-1:0]);
            REG_TEX_HEIGHT:    tex_h      = int'(raw[SIZE_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic set_sprite(input int l, input int r, input int t, input int b,
                              input int w, input int h);
        write_reg(REG_SPRITE_LEFT, l);
        write_reg(REG_SPRITE_RIGHT, r);
        write_reg(REG_SPRITE_TOP, t);
        write_reg(REG_SPRITE_BOTTOM, b);
        write_reg(REG_TEX_WIDTH, w);
        write_reg(REG_TEX_HEIGHT, h);
    endtask

    // Mostly land within or just around the sprite rectangle, now and then anywhere on screen.
    function automatic int pick_coord(input int lo_edge, input int hi_edge);
        int lo;
        int hi;
        lo = (lo_edge - 2 < 0) ? 0 : lo_edge - 2;
        hi = (hi_edge + 1 > SCREEN_MAX) ? SCREEN_MAX : hi_edge + 1;
        if (lo <= hi && $urandom_range(9) < 8)
            return $urandom_range(hi, lo);
        return $urandom_range(SCREEN_MAX, 0);
    endfunction

    // Queue at least n_items requests, counting every load a draw pulls in.
    task automatic queue_random(input int n_items);
        int start;
        start = request_q.size();
        while (request_q.size() - start < n_items) begin
            if ($urandom_range(99) < 30) begin
                if ($urandom_range(9) == 0) begin
                    // out of texture range: dropped by the block
                    if ($urandom_range(1))
                        queue_load($urandom_range(SCREEN_MAX, TEX_DIM),
                                   $urandom_range(SCREEN_MAX, 0), $urandom());
                    else
                        queue_load($urandom_range(SCREEN_MAX, 0),
                                   $urandom_range(SCREEN_MAX, TEX_DIM), $urandom());
                end else begin
                    queue_load($urandom_range(TEX_DIM - 1, 0), $urandom_range(TEX_DIM - 1, 0),
                               random_texel());
                end
            end else begin
                queue_draw(pick_coord(spr_left, spr_right), pick_coord(spr_top, spr_bottom));
            end
        end
    endtask

    int sprite_tab [N_PHASES][6] = '{
        '{-4096, 8191, -4096, 8191, 64, 64},
        '{100, 40, 0, 50, 1, 1},
        '{0, 4096, 0, 4096, 1, 64},
        '{4000, 4096, -20, 30, 64, 64},
        '{200, 203, 300, 301, 17, 5},
        '{-100, 20, 4090, 8191, 64, 1},
        '{37, 37, 12, 80, 33, 64},
        '{16, 48, 8, 72, 32, 64}
    };
    int send_tab  [4] = '{0, 65, 0, 34};
    int stall_tab [4] = '{0, 0, 65, 34};

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset rectangle is empty: nothing inside, nothing fetched
        queue_draw(0, 0);
        queue_draw(SCREEN_MAX, SCREEN_MAX);
        queue_draw(0, SCREEN_MAX);
        wait_drained();

        // One texel per screen pixel, corners and keyed texels
        set_sprite(10, 74, 5, 69, 64, 64);
        queue_load(0, 0, 32'hFFFF_FFFF);
        queue_load(TEX_DIM - 1, TEX_DIM - 1, 32'h0000_0001);
        queue_load(TEX_DIM - 1, 0, 32'hFF00_0000);
        queue_load(0, TEX_DIM - 1, 32'h0080_0000);
        queue_load(TEX_DIM, 0, 32'h1234_5678);
        queue_load(0, TEX_DIM, 32'h8765_4321);
        queue_load(SCREEN_MAX, SCREEN_MAX, 32'h0000_0000);
        queue_draw(10, 5);
        queue_draw(73, 68);
        queue_draw(73, 5);
        queue_draw(10, 68);
        queue_draw(9, 5);
        queue_draw(74, 5);
        queue_draw(10, 4);
        queue_draw(10, 69);
        queue_draw(0, 0);
        queue_draw(SCREEN_MAX, SCREEN_MAX);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            send_idle_pct = send_tab[p % 4];
            stall_pct     = stall_tab[p % 4];
            set_sprite(sprite_tab[p][0], sprite_tab[p][1], sprite_tab[p][2],
                       sprite_tab[p][3], sprite_tab[p][4], sprite_tab[p][5]);
            // hold the sender mid-phase until every pixel is back
            queue_random(PHASE_ITEMS / 2);
            wait_drained();
            queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            wait_drained();
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/sspb_pkg.sv
design/sspb_ram.sv
design/sspb_front.sv
design/sspb_scaler.sv
design/scaled_sprite_pixel_blit.sv
test/scaled_sprite_pixel_blit_test.sv
